/* rtl/rts_pkg.sv */
package rts_pkg;

  localparam int MAX_RECORDS = 32;
  localparam int NAME_WORDS  = 4;
  localparam int TYPE_WORDS  = 3;
  localparam int ENTRY_W     = $clog2(MAX_RECORDS);
  localparam int COUNT_W     = $clog2(MAX_RECORDS + 1);
  localparam int WORD_W      = $clog2(NAME_WORDS);
  localparam int TALLY_W     = 16;

  typedef enum logic [3:0] {
    CMD_CLEAR     = 4'd0,
    CMD_NAME_WORD = 4'd1,
    CMD_TYPE_WORD = 4'd2,
    CMD_APPEND    = 4'd3,
    CMD_SORT_NAME = 4'd4,
    CMD_SORT_TYPE = 4'd5,
    CMD_SORT_PRIO = 4'd6,
    CMD_KEY_WORD  = 4'd7,
    CMD_SEARCH    = 4'd8,
    CMD_READ      = 4'd9
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

endpackage

/* rtl/record_table_sort_and_search.sv */
// Staging, clear, unused and refused commands go from idle straight to S_FIN; append
// writes via S_APP, read via S_RRD and S_REV. Sorts and search read a word in S_CRD
// and check it in S_CEV; sorts step in S_ADV, swap via S_SRD/S_SWA/S_SWB; name sort
// is a bubble sort. One command at a time; start is taken only while busy is low.
// The receiver cannot stall: done marks each result for exactly one cycle.
// Reset (synchronous rst) empties the table and zeroes staged words and tally.
module record_table_sort_and_search (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  command,
  input  logic [2:0]  word_index,
  input  logic [63:0] data_word,
  input  logic [4:0]  entry_index,
  input  logic [7:0]  priority_req,
  output logic        done,
  output logic [1:0]  status,
  output logic [5:0]  record_count,
  output logic [15:0] comparisons,
  output logic        found,
  output logic [4:0]  found_index,
  output logic [63:0] read_word
);

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_APP  = 11'b00000000010,
    S_CRD  = 11'b00000000100,
    S_CEV  = 11'b00000001000,
    S_SRD  = 11'b00000010000,
    S_SWA  = 11'b00000100000,
    S_SWB  = 11'b00001000000,
    S_ADV  = 11'b00010000000,
    S_RRD  = 11'b00100000000,
    S_REV  = 11'b01000000000,
    S_FIN  = 11'b10000000000
  } state_t;

  localparam int AW = rts_pkg::ENTRY_W + rts_pkg::WORD_W;

  state_t                        state;
  rts_pkg::cmd_t                 cmd;
  logic [2:0]                    w;
  logic [rts_pkg::ENTRY_W-1:0]   idx;
  logic [7:0]                    prio;
  logic [rts_pkg::COUNT_W-1:0]   count;
  logic [rts_pkg::TALLY_W-1:0]   tally;
  logic [63:0]                   staged_name [rts_pkg::NAME_WORDS];
  logic [63:0]                   staged_type [rts_pkg::TYPE_WORDS];
  logic [63:0]                   search_key [rts_pkg::NAME_WORDS];
  logic [rts_pkg::ENTRY_W-1:0]   ea;
  logic [rts_pkg::ENTRY_W-1:0]   eb;
  logic [rts_pkg::WORD_W-1:0]    k;
  logic [rts_pkg::COUNT_W-1:0]   i;
  logic [rts_pkg::COUNT_W-1:0]   j;
  logic [rts_pkg::COUNT_W-1:0]   m;
  logic                          hit;
  logic signed [6:0]             lo;
  logic signed [6:0]             hi;

  // Table memories.
  logic            mem_re;
  logic            name_we, type_we, prio_we;
  logic [AW-1:0]   name_wa, type_wa, name_ra, name_rb, type_ra, type_rb;
  logic [rts_pkg::ENTRY_W-1:0] prio_wa, prio_ra, prio_rb;
  logic [63:0]     name_wd, type_wd, name_da, name_db, type_da, type_db;
  logic [7:0]      prio_wd, prio_da, prio_db;

  rts_ram #(.WIDTH(64), .DEPTH(rts_pkg::MAX_RECORDS * rts_pkg::NAME_WORDS)) u_name_ram (
    .clk(clk), .we(name_we), .waddr(name_wa), .wdata(name_wd), .re(mem_re),
    .raddr_a(name_ra), .raddr_b(name_rb), .rdata_a(name_da), .rdata_b(name_db)
  );

  rts_ram #(.WIDTH(64), .DEPTH(rts_pkg::MAX_RECORDS * rts_pkg::NAME_WORDS)) u_type_ram (
    .clk(clk), .we(type_we), .waddr(type_wa), .wdata(type_wd), .re(mem_re),
    .raddr_a(type_ra), .raddr_b(type_rb), .rdata_a(type_da), .rdata_b(type_db)
  );

  rts_ram #(.WIDTH(8), .DEPTH(rts_pkg::MAX_RECORDS)) u_prio_ram (
    .clk(clk), .we(prio_we), .waddr(prio_wa), .wdata(prio_wd), .re(mem_re),
    .raddr_a(prio_ra), .raddr_b(prio_rb), .rdata_a(prio_da), .rdata_b(prio_db)
  );

  logic [2:0] w_type;
  assign w_type = w - 3'd4;

  always_comb begin
    mem_re  = (state == S_CRD) || (state == S_SRD) || (state == S_RRD);
    name_ra = (state == S_RRD) ? {idx, w[rts_pkg::WORD_W-1:0]} : {ea, k};
    type_ra = (state == S_RRD) ? {idx, w_type[rts_pkg::WORD_W-1:0]} : {ea, k};
    prio_ra = (state == S_RRD) ? idx : ea;
    name_rb = {eb, k};
    type_rb = {eb, k};
    prio_rb = eb;

    name_we = 1'b0;
    type_we = 1'b0;
    prio_we = 1'b0;
    name_wa = {ea, k};
    type_wa = {ea, k};
    prio_wa = ea;
    name_wd = name_db;
    type_wd = type_db;
    prio_wd = prio_db;
    unique case (state)
      S_APP: begin
        name_we = 1'b1;
        type_we = (32'(k) < rts_pkg::TYPE_WORDS);
        prio_we = (k == '0);
        name_wa = {count[rts_pkg::ENTRY_W-1:0], k};
        type_wa = {count[rts_pkg::ENTRY_W-1:0], k};
        prio_wa = count[rts_pkg::ENTRY_W-1:0];
        name_wd = staged_name[k];
        type_wd = (32'(k) < rts_pkg::TYPE_WORDS) ? staged_type[k[1:0] == 2'd3 ? 2'd0 : k] : '0;
        prio_wd = prio;
      end
      S_SWA: begin
        name_we = 1'b1;
        type_we = (32'(k) < rts_pkg::TYPE_WORDS);
        prio_we = (k == '0);
      end
      S_SWB: begin
        name_we = 1'b1;
        type_we = (32'(k) < rts_pkg::TYPE_WORDS);
        prio_we = (k == '0);
        name_wa = {eb, k};
        type_wa = {eb, k};
        prio_wa = eb;
        name_wd = name_da;
        type_wd = type_da;
        prio_wd = prio_da;
      end
      default: ;
    endcase
  end

  // Word compare of entry ea against entry eb, or against the search key.
  logic [63:0]                cmp_a, cmp_b;
  logic [rts_pkg::WORD_W-1:0] last_k;
  logic                       diff, gt;
  logic [rts_pkg::TALLY_W-1:0] tally_inc;

  always_comb begin
    cmp_a  = name_da;
    cmp_b  = name_db;
    last_k = rts_pkg::WORD_W'(rts_pkg::NAME_WORDS - 1);
    case (cmd)
      rts_pkg::CMD_SORT_TYPE: begin
        cmp_a  = type_da;
        cmp_b  = type_db;
        last_k = rts_pkg::WORD_W'(rts_pkg::TYPE_WORDS - 1);
      end
      rts_pkg::CMD_SORT_PRIO: begin
        cmp_a  = {56'd0, prio_da};
        cmp_b  = {56'd0, prio_db};
        last_k = '0;
      end
      rts_pkg::CMD_SEARCH: cmp_b = search_key[k];
      default: ;
    endcase
    diff      = (cmp_a != cmp_b);
    gt        = (cmp_a > cmp_b);
    tally_inc = (tally == '1) ? tally : tally + 1'b1;
  end

  // Binary search bounds after the current probe.
  logic signed [6:0] mid_s, lo_n, hi_n, sum_n, mid_n;
  always_comb begin
    mid_s = signed'({2'b00, ea});
    lo_n  = gt ? lo : mid_s + 7'sd1;
    hi_n  = gt ? mid_s - 7'sd1 : hi;
    sum_n = lo_n + hi_n;
    mid_n = sum_n >>> 1;
  end

  logic [rts_pkg::COUNT_W-1:0] jn, in_n, jd;
  assign jn   = j + 1'b1;
  assign jd   = j - 1'b1;
  assign in_n = i + 1'b1;

  assign busy         = (state != S_IDLE);
  assign done         = (state == S_FIN);
  assign record_count = count;
  assign comparisons  = tally;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      tally <= '0;
      for (int x = 0; x < rts_pkg::NAME_WORDS; x++) begin
        staged_name[x] <= '0;
        search_key[x]  <= '0;
      end
      for (int x = 0; x < rts_pkg::TYPE_WORDS; x++) begin
        staged_type[x] <= '0;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            cmd         <= rts_pkg::cmd_t'(command);
            w           <= word_index;
            idx         <= entry_index;
            prio        <= priority_req;
            status      <= rts_pkg::ST_OK;
            found       <= 1'b0;
            found_index <= '0;
            read_word   <= '0;
            k           <= '0;
            hit         <= 1'b0;
            state       <= S_FIN;
            case (rts_pkg::cmd_t'(command))
              rts_pkg::CMD_CLEAR: begin
                count <= '0;
                tally <= '0;
                for (int x = 0; x < rts_pkg::NAME_WORDS; x++) begin
                  staged_name[x] <= '0;
                  search_key[x]  <= '0;
                end
                for (int x = 0; x < rts_pkg::TYPE_WORDS; x++) begin
                  staged_type[x] <= '0;
                end
              end
              rts_pkg::CMD_NAME_WORD: begin
                if (32'(word_index) < rts_pkg::NAME_WORDS) begin
                  staged_name[word_index[rts_pkg::WORD_W-1:0]] <= data_word;
                end
              end
              rts_pkg::CMD_TYPE_WORD: begin
                if (32'(word_index) < rts_pkg::TYPE_WORDS) begin
                  staged_type[word_index[1:0]] <= data_word;
                end
              end
              rts_pkg::CMD_KEY_WORD: begin
                if (32'(word_index) < rts_pkg::NAME_WORDS) begin
                  search_key[word_index[rts_pkg::WORD_W-1:0]] <= data_word;
                end
              end
              rts_pkg::CMD_APPEND: begin
                if (32'(count) >= rts_pkg::MAX_RECORDS) begin
                  status <= rts_pkg::ST_FULL;
                end else begin
                  state <= S_APP;
                end
              end
              rts_pkg::CMD_SORT_NAME, rts_pkg::CMD_SORT_PRIO: begin
                tally <= '0;
                i     <= '0;
                j     <= rts_pkg::CMD_SORT_NAME == rts_pkg::cmd_t'(command) ?
                         '0 : rts_pkg::COUNT_W'(1);
                m     <= '0;
                ea    <= rts_pkg::CMD_SORT_NAME == rts_pkg::cmd_t'(command) ?
                         '0 : rts_pkg::ENTRY_W'(1);
                eb    <= rts_pkg::CMD_SORT_NAME == rts_pkg::cmd_t'(command) ?
                         rts_pkg::ENTRY_W'(1) : '0;
                if (count >= 2) begin
                  state <= S_CRD;
                end
              end
              rts_pkg::CMD_SORT_TYPE: begin
                tally <= '0;
                i     <= rts_pkg::COUNT_W'(1);
                j     <= rts_pkg::COUNT_W'(1);
                ea    <= '0;
                eb    <= rts_pkg::ENTRY_W'(1);
                if (count >= 2) begin
                  state <= S_CRD;
                end
              end
              rts_pkg::CMD_SEARCH: begin
                tally <= '0;
                lo    <= '0;
                hi    <= signed'(7'(count) - 7'd1);
                ea    <= rts_pkg::ENTRY_W'((count - 1'b1) >> 1);
                if (count == '0) begin
                  status <= rts_pkg::ST_EMPTY;
                end else begin
                  state <= S_CRD;
                end
              end
              rts_pkg::CMD_READ: begin
                if (rts_pkg::COUNT_W'(entry_index) >= count) begin
                  status <= rts_pkg::ST_RANGE;
                end else begin
                  state <= S_RRD;
                end
              end
              default: ;
            endcase
          end
        end

        S_APP: begin
          if (32'(k) == rts_pkg::NAME_WORDS - 1) begin
            count <= count + 1'b1;
            state <= S_FIN;
          end else begin
            k <= k + 1'b1;
          end
        end

        S_CRD: state <= S_CEV;

        S_CEV: begin
          if (!diff && k != last_k) begin
            k     <= k + 1'b1;
            state <= S_CRD;
          end else begin
            k <= '0;
            case (cmd)
              rts_pkg::CMD_SORT_NAME: begin
                tally <= tally_inc;
                state <= (diff && gt) ? S_SRD : S_ADV;
              end
              rts_pkg::CMD_SORT_TYPE: begin
                if (diff && gt) begin
                  tally <= tally_inc;
                  hit   <= 1'b1;
                  state <= S_SRD;
                end else begin
                  hit   <= 1'b0;
                  state <= S_ADV;
                end
              end
              rts_pkg::CMD_SORT_PRIO: begin
                tally <= tally_inc;
                hit   <= 1'b0;
                if (diff && !gt) begin
                  m <= j;
                end
                state <= S_ADV;
              end
              default: begin
                // Binary search probe.
                tally <= tally_inc;
                if (!diff) begin
                  found       <= 1'b1;
                  found_index <= ea;
                  state       <= S_FIN;
                end else begin
                  lo <= lo_n;
                  hi <= hi_n;
                  ea <= rts_pkg::ENTRY_W'(mid_n);
                  state <= (lo_n <= hi_n) ? S_CRD : S_FIN;
                end
              end
            endcase
          end
        end

        S_SRD: state <= S_SWA;
        S_SWA: state <= S_SWB;
        S_SWB: begin
          if (32'(k) == rts_pkg::NAME_WORDS - 1) begin
            k     <= '0;
            state <= S_ADV;
          end else begin
            k     <= k + 1'b1;
            state <= S_SRD;
          end
        end

        S_ADV: begin
          state <= S_CRD;
          case (cmd)
            rts_pkg::CMD_SORT_NAME: begin
              if (jn + 1'b1 < count - i) begin
                j  <= jn;
                ea <= rts_pkg::ENTRY_W'(jn);
                eb <= rts_pkg::ENTRY_W'(jn + 1'b1);
              end else if (in_n + 1'b1 < count) begin
                i  <= in_n;
                j  <= '0;
                ea <= '0;
                eb <= rts_pkg::ENTRY_W'(1);
              end else begin
                state <= S_FIN;
              end
            end
            rts_pkg::CMD_SORT_TYPE: begin
              if (hit && jd != '0) begin
                j  <= jd;
                ea <= rts_pkg::ENTRY_W'(jd - 1'b1);
                eb <= rts_pkg::ENTRY_W'(jd);
              end else if (in_n < count) begin
                i  <= in_n;
                j  <= in_n;
                ea <= rts_pkg::ENTRY_W'(in_n - 1'b1);
                eb <= rts_pkg::ENTRY_W'(in_n);
              end else begin
                state <= S_FIN;
              end
              hit <= 1'b0;
            end
            default: begin
              // Selection sort: scan for the minimum, then at most one swap per pass.
              if (!hit && jn < count) begin
                j  <= jn;
                ea <= rts_pkg::ENTRY_W'(jn);
                eb <= rts_pkg::ENTRY_W'(m);
              end else if (!hit && m != i) begin
                hit   <= 1'b1;
                ea    <= rts_pkg::ENTRY_W'(i);
                eb    <= rts_pkg::ENTRY_W'(m);
                state <= S_SRD;
              end else if (in_n + 1'b1 < count) begin
                hit <= 1'b0;
                i   <= in_n;
                m   <= in_n;
                j   <= in_n + 1'b1;
                ea  <= rts_pkg::ENTRY_W'(in_n + 1'b1);
                eb  <= rts_pkg::ENTRY_W'(in_n);
              end else begin
                hit   <= 1'b0;
                state <= S_FIN;
              end
            end
          endcase
        end

        S_RRD: state <= S_REV;

        S_REV: begin
          if (w < 3'd4) begin
            read_word <= name_da;
          end else if (w < 3'd7) begin
            read_word <= type_da;
          end else begin
            read_word <= {56'd0, prio_da};
          end
          state <= S_FIN;
        end

        S_FIN: state <= S_IDLE;

        default: state <= S_IDLE;
      endcase
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted command did not make the block busy");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    record_count <= 6'(rts_pkg::MAX_RECORDS))
    else $error("record count beyond table size");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  a_found_index: assert property (@(posedge clk) disable iff (rst)
    done && found |-> 6'(found_index) < record_count)
    else $error("search hit outside held entries");

endmodule

/* rtl/rts_ram.sv */
module rts_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule
